>>> rtl/core/tms_pkg.sv
// Shared constants and controller/datapath interface types for the median select core
`default_nettype none
package tms_pkg;

  // Default depth of the kept-value store
  localparam int MAX_ITEMS_DEF = 256;

  // Fixed field widths
  localparam int VAL_W = 32;
  localparam int TAG_W = 8;

  // Flip the sign bit so signed order becomes unsigned order
  localparam logic [VAL_W-1:0] SIGN_FLIP = {1'b1, {(VAL_W-1){1'b0}}};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;       // input request accepted this cycle
    logic init;       // start a rank selection over the kept values
    logic scan_rd;    // issue one store read of the current pass
    logic decide;     // settle one result bit from the pass tally
    logic result_ld;  // load the output register and clear the data set
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic count_zero; // no value kept in this data set
    logic rd_last;    // current read address is the last kept entry
    logic bit_last;   // the pass just tallied decides the lowest bit
  } stat_t;

endpackage
`default_nettype wire

>>> rtl/core/tms_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module tms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/core/tms_datapath.sv
// Datapath: kept-value store, counters and bit-by-bit rank selection
`default_nettype none
module tms_datapath #(
  parameter int MAX_ITEMS = tms_pkg::MAX_ITEMS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire tms_pkg::cmd_t                   cmd,
  output tms_pkg::stat_t                       stat,
  input  wire logic signed [tms_pkg::VAL_W-1:0] in_value,
  input  wire logic [tms_pkg::TAG_W-1:0]       in_group_tag,
  input  wire logic                            cfg_we,
  input  wire logic [tms_pkg::TAG_W-1:0]       cfg_data,
  output logic signed [tms_pkg::VAL_W-1:0]     out_median,
  output logic                                 out_none_matched,
  output logic                                 out_overflowed
);

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int VW    = tms_pkg::VAL_W;

  logic [tms_pkg::TAG_W-1:0] target_r;
  logic [CNT_W-1:0]          count_r;
  logic                      ovf_r;
  logic [VW-1:0]             prefix_r;
  logic [VW-1:0]             mask_r;
  logic [VW-1:0]             bit_r;
  logic [CNT_W-1:0]          k_r;
  logic [CNT_W-1:0]          tally_r;
  logic [IDX_W-1:0]          rd_addr_r;
  logic                      rd_vld_r;

  logic          match;
  logic          room;
  logic          ram_we;
  logic [VW-1:0] ram_q;
  logic          hit;

  // Qualify the incoming request against the configured group
  assign match  = (in_group_tag == target_r);
  assign room   = (count_r < CNT_W'(MAX_ITEMS));
  assign ram_we = cmd.take && match && room;

  tms_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata ($unsigned(in_value) ^ tms_pkg::SIGN_FLIP),
    .raddr (rd_addr_r),
    .rdata (ram_q)
  );

  // Entry agrees with the prefix above the current bit and has a zero there
  assign hit = (((ram_q ^ prefix_r) & mask_r) == '0);

  assign stat.count_zero = (count_r == '0);
  assign stat.rd_last    = (CNT_W'(rd_addr_r) == (count_r - CNT_W'(1)));
  assign stat.bit_last   = bit_r[0];

  // Control registers: group, fill count, overflow, read pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        target_r <= cfg_data;
      end
      rd_vld_r <= cmd.scan_rd;
      if (cmd.result_ld) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else if (cmd.take && match) begin
        if (room) begin
          count_r <= count_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  // Selection registers: one pass over the store per result bit
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      prefix_r  <= '0;
      mask_r    <= tms_pkg::SIGN_FLIP;
      bit_r     <= tms_pkg::SIGN_FLIP;
      k_r       <= count_r >> 1;
      tally_r   <= '0;
      rd_addr_r <= '0;
    end else if (cmd.decide) begin
      // Keep the bit at zero if the rank falls among the zero-bit entries
      if (k_r >= tally_r) begin
        prefix_r <= prefix_r | bit_r;
        k_r      <= k_r - tally_r;
      end
      mask_r    <= {1'b1, mask_r[VW-1:1]};
      bit_r     <= bit_r >> 1;
      tally_r   <= '0;
      rd_addr_r <= '0;
    end else begin
      if (cmd.scan_rd) begin
        rd_addr_r <= rd_addr_r + IDX_W'(1);
      end
      if (rd_vld_r && hit) begin
        tally_r <= tally_r + CNT_W'(1);
      end
    end
  end

  // Capture the result
  always_ff @(posedge clk) begin
    if (cmd.result_ld) begin
      out_median       <= stat.count_zero ? '0 : $signed(prefix_r ^ tms_pkg::SIGN_FLIP);
      out_none_matched <= stat.count_zero;
      out_overflowed   <= ovf_r;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/tms_ctrl.sv
// Controller: sequences loading, per-bit selection passes and result delivery
`default_nettype none
module tms_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_last_item,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire tms_pkg::stat_t stat,
  output tms_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Decode commands from the current state
  always_comb begin
    cmd           = '0;
    cmd.take      = in_valid && (state_r == S_LOAD);
    cmd.init      = (state_r == S_START) && !stat.count_zero;
    cmd.scan_rd   = (state_r == S_SCAN);
    cmd.decide    = (state_r == S_DECIDE);
    cmd.result_ld = (state_r == S_FINISH) && out_free;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (cmd.take && in_last_item) state_nxt = S_START;
      end
      S_START: begin
        state_nxt = stat.count_zero ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        if (stat.rd_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = stat.bit_last ? S_FINISH : S_SCAN;
      end
      S_FINISH: begin
        if (out_free) state_nxt = S_LOAD;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Hold the result valid until it is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.result_ld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/tagged_median_select_core.sv
// Top level of the tagged median select core
`default_nettype none
// Takes one request per cycle while loading; requests whose group_tag equals the
// configured target group are kept (up to MAX_ITEMS, later matches only set the
// overflow flag). After the request marked last, the core stalls its input and
// finds the kept value at ascending rank floor(n/2) by settling one result bit
// per pass over the single-read-port store, MSB first: each pass reads every
// kept value once, waits for the last read data and then settles the bit. The
// passes are skipped when nothing matched, and the result is held back while
// a previous result still waits in the output register. The next
// data set is accepted once the result sits in the output register. The target
// group register takes writes at any time and should only be written while the
// core is idle.
module tagged_median_select_core #(
  parameter int MAX_ITEMS = tms_pkg::MAX_ITEMS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [tms_pkg::VAL_W-1:0] in_value,
  input  wire logic [tms_pkg::TAG_W-1:0]        in_group_tag,
  input  wire logic                             in_last_item,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [tms_pkg::VAL_W-1:0]      out_median,
  output logic                                  out_none_matched,
  output logic                                  out_overflowed,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tms_pkg::TAG_W-1:0]        cfg_data
);

  tms_pkg::cmd_t  cmd;
  tms_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  tms_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_item (in_last_item),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  tms_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_value         (in_value),
    .in_group_tag     (in_group_tag),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .out_median       (out_median),
    .out_none_matched (out_none_matched),
    .out_overflowed   (out_overflowed)
  );

`ifndef ASSERT_OFF
  // No request is taken while the store is being scanned
  a_take_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |-> !(cmd.scan_rd || cmd.decide || cmd.result_ld))
    else $error("request taken during selection");

  // A result never overwrites one that is still waiting
  a_ld_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result_ld |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending result");

  // A loaded result is offered in the next cycle
  a_ld_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result_ld |=> out_valid)
    else $error("loaded result not offered");

  // The last request of a data set closes the input
  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_item) |=> in_stall)
    else $error("input open after last request");
`endif

endmodule
`default_nettype wire

>>> test/tb_tagged_median_select_core.sv
// Testbench for tagged_median_select_core: directed table, then predictor-checked random sets
`timescale 1ns / 1ps
module tb_tagged_median_select_core;

  localparam int MAX_ITEMS      = tms_pkg::MAX_ITEMS_DEF;
  localparam int VAL_W          = tms_pkg::VAL_W;
  localparam int TAG_W          = tms_pkg::TAG_W;
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int SETTLE_CYCLES  = 40;

  // Idle behavior of the two channels
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] median;
    logic                    none_matched;
    logic                    overflowed;
  } median_result_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [TAG_W-1:0]        group_tag;
    logic                    last_item;
    logic                    typed;
    median_result_t          want;
  } dir_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [VAL_W-1:0] in_value;
  logic [TAG_W-1:0]        in_group_tag;
  logic                    in_last_item;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [VAL_W-1:0] out_median;
  logic                    out_none_matched;
  logic                    out_overflowed;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [TAG_W-1:0]        cfg_data;

  // Predictor state
  logic [TAG_W-1:0]        target_grp;
  logic signed [VAL_W-1:0] kept_in_order[$];
  logic                    overflow_pending;
  median_result_t          pending_medians[$];

  idle_mode_t              idle_mode;
  int                      mismatch_count;
  int                      items_sent;
  median_result_t          no_result;
  dir_row_t                dir_rows[21];

  tagged_median_select_core #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .in_group_tag    (in_group_tag),
    .in_last_item    (in_last_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_median      (out_median),
    .out_none_matched(out_none_matched),
    .out_overflowed  (out_overflowed),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic dir_row_t mk_row(input logic signed [VAL_W-1:0] v,
                                      input logic [TAG_W-1:0] g,
                                      input logic l, input logic t,
                                      input logic signed [VAL_W-1:0] m, input logic n,
                                      input logic o);
    dir_row_t row;
    row.value = v;
    row.group_tag = g;
    row.last_item = l;
    row.typed = t;
    row.want.median = m;
    row.want.none_matched = n;
    row.want.overflowed = o;
    return row;
  endfunction

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 49;
      IDLE_BOTH:   return $urandom_range(99) < 8;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99) < 49;
      IDLE_BOTH:     return $urandom_range(99) < 8;
      default:       return 1'b0;
    endcase
  endfunction

  // Mix wide values, clustered values with duplicates, and the extremes
  function automatic logic signed [VAL_W-1:0] rand_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return $urandom;
    if (pick < 70) return $signed($urandom_range(20)) - 10;
    if (pick < 85) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    if ($urandom_range(1) == 0) return 32'sh8000_0000 + $signed($urandom_range(3));
    return 32'sh7FFF_FFFF - $signed($urandom_range(3));
  endfunction

  function automatic logic [TAG_W-1:0] rand_tag(input int match_pct);
    if ($urandom_range(99) < match_pct) return target_grp;
    return TAG_W'($urandom_range(255));
  endfunction

  // Fold one accepted request into the predictor; queue the median on the last one
  task automatic absorb_element(input logic signed [VAL_W-1:0] v, input logic [TAG_W-1:0] g,
                                input logic l, input bit typed, input median_result_t typed_res);
    median_result_t res;
    int pos;
    if (g == target_grp) begin
      if (kept_in_order.size() < MAX_ITEMS) begin
        pos = 0;
        while (pos < kept_in_order.size() && kept_in_order[pos] <= v) pos++;
        kept_in_order.insert(pos, v);
      end else begin
        overflow_pending = 1'b1;
      end
    end
    if (l) begin
      if (kept_in_order.size() == 0) begin
        res.median = '0;
        res.none_matched = 1'b1;
      end else begin
        res.median = kept_in_order[kept_in_order.size() / 2];
        res.none_matched = 1'b0;
      end
      res.overflowed = overflow_pending;
      if (typed) res = typed_res;
      pending_medians.push_back(res);
      kept_in_order.delete();
      overflow_pending = 1'b0;
    end
  endtask

  // Offer one request, hold it until accepted; starts and ends at a falling edge
  task automatic send_item(input logic signed [VAL_W-1:0] v, input logic [TAG_W-1:0] g,
                           input logic l, input bit typed, input median_result_t typed_res);
    while (sender_gap()) begin
      in_valid = 1'b0;
      in_value = $urandom;
      in_group_tag = TAG_W'($urandom);
      in_last_item = 1'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_value = v;
    in_group_tag = g;
    in_last_item = l;
    do @(posedge clk); while (in_stall);
    absorb_element(v, g, l, typed, typed_res);
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Hold the sender until every queued median has come back
  task automatic drain_results();
    while (pending_medians.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_target(input logic [TAG_W-1:0] grp);
    cfg_valid = 1'b1;
    cfg_data = grp;
    do @(posedge clk); while (!cfg_ready);
    target_grp = grp;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Short data sets of random length and match density
  task automatic run_short_sets(input int budget);
    int start;
    int len;
    int match_pct;
    int i;
    start = items_sent;
    while (items_sent - start < budget) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      case ($urandom_range(9))
        0:       match_pct = 0;
        1, 2:    match_pct = 30;
        default: match_pct = 80;
      endcase
      for (i = 0; i < len; i++)
        send_item(rand_value(), rand_tag(match_pct), i == len - 1, 1'b0, no_result);
      if ($urandom_range(15) == 0) drain_results();
    end
  endtask

  // One data set of n matching requests, to fill or overrun the store
  task automatic run_full_set(input int n);
    int i;
    for (i = 0; i < n; i++)
      send_item(rand_value(), target_grp, i == n - 1, 1'b0, no_result);
  endtask

  // Drive the result stall on falling edges
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = receiver_stall();
    end
  end

  // Compare each accepted result with the oldest queued median
  initial begin
    median_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_medians.size() == 0) begin
          $error("unexpected result: median %0d none_matched %0b overflowed %0b",
                 out_median, out_none_matched, out_overflowed);
          mismatch_count++;
        end else begin
          want = pending_medians.pop_front();
          if (out_median !== want.median) begin
            $error("median: expected %0d, got %0d", want.median, out_median);
            mismatch_count++;
          end
          if (out_none_matched !== want.none_matched) begin
            $error("none_matched: expected %0b, got %0b", want.none_matched, out_none_matched);
            mismatch_count++;
          end
          if (out_overflowed !== want.overflowed) begin
            $error("overflowed: expected %0b, got %0b", want.overflowed, out_overflowed);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Stop the run when no request moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tagged_median_select_core test failed");
    $finish;
  end

  initial begin
    int r;
    int ph;
    logic [TAG_W-1:0] grp;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    in_group_tag = '0;
    in_last_item = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    target_grp = '0;
    overflow_pending = 1'b0;
    mismatch_count = 0;
    items_sent = 0;
    no_result = '0;
    idle_mode = IDLE_NONE;

    // Directed sets, run against the reset target group of zero
    dir_rows[0]  = mk_row(32'sd5, 8'd0, 1'b1, 1'b1, 32'sd5, 1'b0, 1'b0);
    dir_rows[1]  = mk_row(32'sd7, 8'd1, 1'b1, 1'b1, 32'sd0, 1'b1, 1'b0);
    dir_rows[2]  = mk_row(32'sh7FFF_FFFF, 8'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    dir_rows[3]  = mk_row(32'sh8000_0000, 8'd0, 1'b1, 1'b1, 32'sh7FFF_FFFF, 1'b0, 1'b0);
    dir_rows[4]  = mk_row(-32'sd1, 8'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    dir_rows[5]  = mk_row(32'sd0, 8'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    dir_rows[6]  = mk_row(32'sd1, 8'd0, 1'b1, 1'b1, 32'sd0, 1'b0, 1'b0);
    dir_rows[7]  = mk_row(32'sd3, 8'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    dir_rows[8]  = mk_row(32'sd3, 8'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    dir_rows[9]  = mk_row(-32'sd2, 8'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    dir_rows[10] = mk_row(32'sd3, 8'd9, 1'b1, 1'b1, 32'sd3, 1'b0, 1'b0);
    dir_rows[11] = mk_row(32'sd100, 8'd255, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    dir_rows[12] = mk_row(-32'sd50, 8'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    dir_rows[13] = mk_row(32'sd20, 8'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    dir_rows[14] = mk_row(-32'sd7, 8'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    dir_rows[15] = mk_row(32'sd8, 8'd200, 1'b1, 1'b0, '0, 1'b0, 1'b0);
    dir_rows[16] = mk_row(32'sh8000_0000, 8'd0, 1'b1, 1'b1, 32'sh8000_0000, 1'b0, 1'b0);
    dir_rows[17] = mk_row(32'sd12345, 8'hAA, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    dir_rows[18] = mk_row(32'sd1, 8'h55, 1'b1, 1'b1, 32'sd0, 1'b1, 1'b0);
    dir_rows[19] = mk_row(32'sd4, 8'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    dir_rows[20] = mk_row(32'sd4, 8'd0, 1'b1, 1'b1, 32'sd4, 1'b0, 1'b0);

    // Hold reset, then release it on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (r = 0; r < 21; r++)
      send_item(dir_rows[r].value, dir_rows[r].group_tag, dir_rows[r].last_item,
                dir_rows[r].typed, dir_rows[r].want);

    // Random phases, each with its own idle pattern and target group
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_mode = IDLE_NONE;     grp = 8'd255; end
        1: begin idle_mode = IDLE_SENDER;   grp = 8'd0; end
        2: begin idle_mode = IDLE_RECEIVER; grp = TAG_W'($urandom_range(1, 254)); end
        3: begin idle_mode = IDLE_BOTH;     grp = 8'hA5; end
        default: begin idle_mode = IDLE_NONE; grp = TAG_W'($urandom_range(255)); end
      endcase
      drain_results();
      repeat (10) @(negedge clk);
      write_target(grp);
      run_short_sets(150);
      if (ph == 1 || ph == 4) run_full_set(MAX_ITEMS + $urandom_range(1, 4));
      if (ph == 3) run_full_set(MAX_ITEMS);
    end

    while (pending_medians.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_medians.size() == 0)
      $display("tagged_median_select_core test passed");
    else
      $display("tagged_median_select_core test failed");
    $finish;
  end

endmodule
